// ===== hw/rtl/itrt_pkg.sv =====
package itrt_pkg;

  localparam int unsigned RADIX_W           = 6;
  localparam int unsigned CHAR_W            = 7;
  localparam int unsigned IN_W              = 64;
  localparam int unsigned VALUE_WIDTH_DEF   = 64;
  localparam int unsigned MAX_DIGITS_DEF    = 64;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

  localparam logic [RADIX_W-1:0] DIGIT_NINE  = 6'd9;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 7'd48;
  localparam logic [CHAR_W-1:0]  CHAR_A_OFFS = 7'd87;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_EMIT = 3'b100
  } back_state_e;

  function automatic logic [RADIX_W-1:0] sat_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] s;
    s = r;
    if (r < RADIX_MIN) s = RADIX_MIN;
    if (r > RADIX_MAX) s = RADIX_MAX;
    return s;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] c;
    c = {1'b0, d} + ((d > DIGIT_NINE) ? CHAR_A_OFFS : CHAR_ZERO);
    return c;
  endfunction

endpackage

// ===== hw/rtl/itrt_ram.sv =====
module itrt_ram #(
  parameter int unsigned WIDTH = 6,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/itrt_front.sv =====
module itrt_front #(
  parameter int unsigned VALUE_WIDTH = itrt_pkg::VALUE_WIDTH_DEF,
  localparam int unsigned ITEM_W = VALUE_WIDTH + itrt_pkg::RADIX_W + 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [itrt_pkg::IN_W-1:0]    value_i,
  input  logic                         radix_we_i,
  input  logic [itrt_pkg::RADIX_W-1:0] radix_i,
  input  logic                         full_i,
  output logic                         push_o,
  output logic [ITEM_W-1:0]            push_data_o
);

  logic [itrt_pkg::RADIX_W-1:0] radix_q, radix_d;
  logic [VALUE_WIDTH-1:0]       val;
  logic                         is_zero;

  assign radix_d = itrt_pkg::sat_radix(radix_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= itrt_pkg::RADIX_RESET;
    end else if (radix_we_i) begin
      radix_q <= radix_d;
    end
  end

  assign val         = value_i[VALUE_WIDTH-1:0];
  assign is_zero     = (val == '0);
  assign push_o      = start_i && !full_i;
  assign push_data_o = {is_zero, radix_q, val};

endmodule

// ===== hw/rtl/itrt_fifo.sv =====
module itrt_fifo #(
  parameter int unsigned WIDTH = 71
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned DEPTH = 2;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q, cnt_d;

  assign full_o     = (cnt_q == 2'(DEPTH));
  assign empty_o    = (cnt_q == 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + 2'd1;
    if (!push_i && pop_i) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hw/rtl/itrt_back.sv =====
module itrt_back #(
  parameter int unsigned VALUE_WIDTH = itrt_pkg::VALUE_WIDTH_DEF,
  parameter int unsigned MAX_DIGITS  = itrt_pkg::MAX_DIGITS_DEF,
  localparam int unsigned ITEM_W = VALUE_WIDTH + itrt_pkg::RADIX_W + 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        empty_i,
  input  logic [ITEM_W-1:0]           pop_data_i,
  output logic                        pop_o,
  output logic                        digit_valid_o,
  output logic [itrt_pkg::CHAR_W-1:0] digit_char_o,
  output logic                        last_o
);

  localparam int unsigned RW    = itrt_pkg::RADIX_W;
  localparam int unsigned AW    = $clog2(MAX_DIGITS);
  localparam int unsigned CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int unsigned BW    = $clog2(VALUE_WIDTH);

  itrt_pkg::back_state_e state_q, state_d;

  logic [VALUE_WIDTH-1:0] quo_q, quo_d, quo_next;
  logic [RW-1:0]          rem_q, rem_d, rem_next;
  logic [RW-1:0]          radix_q, radix_d;
  logic [BW-1:0]          bit_q, bit_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [AW-1:0]          ptr_q, ptr_d;
  logic                   vld_q, vld_d, last_q, last_d;
  logic [RW:0]            partial;
  logic                   ge;

  logic                   item_zero;
  logic [RW-1:0]          item_radix;
  logic [VALUE_WIDTH-1:0] item_value;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [RW-1:0] ram_wdata, ram_rdata;

  assign {item_zero, item_radix, item_value} = pop_data_i;

  // one restoring division step per cycle
  assign partial  = {rem_q, quo_q[VALUE_WIDTH-1]};
  assign ge       = (partial >= {1'b0, radix_q});
  assign rem_next = ge ? RW'(partial - {1'b0, radix_q}) : partial[RW-1:0];
  assign quo_next = {quo_q[VALUE_WIDTH-2:0], ge};

  always_comb begin
    state_d   = state_q;
    quo_d     = quo_q;
    rem_d     = rem_q;
    radix_d   = radix_q;
    bit_d     = bit_q;
    cnt_d     = cnt_q;
    ptr_d     = ptr_q;
    vld_d     = 1'b0;
    last_d    = 1'b0;
    pop_o     = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = cnt_q[AW-1:0];
    ram_wdata = rem_next;
    ram_re    = 1'b0;
    ram_raddr = ptr_q;
    unique case (state_q)
      itrt_pkg::ST_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          radix_d = item_radix;
          quo_d   = item_value;
          rem_d   = '0;
          bit_d   = BW'(VALUE_WIDTH - 1);
          cnt_d   = '0;
          if (item_zero) begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = '0;
            ptr_d     = '0;
            state_d   = itrt_pkg::ST_EMIT;
          end else begin
            state_d = itrt_pkg::ST_DIV;
          end
        end
      end
      itrt_pkg::ST_DIV: begin
        quo_d = quo_next;
        rem_d = rem_next;
        if (bit_q == '0) begin
          ram_we = 1'b1;
          cnt_d  = CNT_W'(cnt_q + 1'b1);
          rem_d  = '0;
          bit_d  = BW'(VALUE_WIDTH - 1);
          if (quo_next == '0 || cnt_q == CNT_W'(MAX_DIGITS - 1)) begin
            ptr_d   = cnt_q[AW-1:0];
            state_d = itrt_pkg::ST_EMIT;
          end
        end else begin
          bit_d = bit_q - 1'b1;
        end
      end
      itrt_pkg::ST_EMIT: begin
        ram_re = 1'b1;
        vld_d  = 1'b1;
        last_d = (ptr_q == '0);
        if (ptr_q == '0) begin
          state_d = itrt_pkg::ST_IDLE;
        end else begin
          ptr_d = ptr_q - 1'b1;
        end
      end
      default: state_d = itrt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= itrt_pkg::ST_IDLE;
      bit_q   <= '0;
      cnt_q   <= '0;
      vld_q   <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      bit_q   <= bit_d;
      cnt_q   <= cnt_d;
      vld_q   <= vld_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q   <= quo_d;
    rem_q   <= rem_d;
    radix_q <= radix_d;
    ptr_q   <= ptr_d;
  end

  itrt_ram #(
    .WIDTH(RW),
    .DEPTH(MAX_DIGITS)
  ) u_digits (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign digit_valid_o = vld_q;
  assign last_o        = last_q;
  assign digit_char_o  = itrt_pkg::digit_to_char(ram_rdata);

endmodule

// ===== hw/rtl/integer_to_radix_text.sv =====
// Channel   Ports                                    Handshake
// input     start_i, value_i[63:0]                   taken when start_i && !busy_o
// config    radix_we_i, radix_i[5:0]                 written when radix_we_i
// output    digit_valid_o, digit_char_o, last_o      one digit per cycle, no stall
//
// After intake, an idle divider pops a value from the queue, runs VALUE_WIDTH
// restoring divide steps per digit, then reads the digits out of the digit
// RAM, highest first. Zero skips the divide steps.
// The worst case is a word of 64 digits for 64-bit values.
// A two-word queue sits between intake and divider; busy_o is high while it
// is full. Reset is asynchronous; the radix returns to 10.
module integer_to_radix_text #(
  parameter int unsigned VALUE_WIDTH = itrt_pkg::VALUE_WIDTH_DEF,
  parameter int unsigned MAX_DIGITS  = itrt_pkg::MAX_DIGITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [itrt_pkg::IN_W-1:0]    value_i,
  input  logic                         radix_we_i,
  input  logic [itrt_pkg::RADIX_W-1:0] radix_i,
  output logic                         digit_valid_o,
  output logic [itrt_pkg::CHAR_W-1:0]  digit_char_o,
  output logic                         last_o
);

  localparam int unsigned ITEM_W = VALUE_WIDTH + itrt_pkg::RADIX_W + 1;

  logic              push, pop, full, empty;
  logic [ITEM_W-1:0] push_data, pop_data;

  itrt_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .value_i    (value_i),
    .radix_we_i (radix_we_i),
    .radix_i    (radix_i),
    .full_i     (full),
    .push_o     (push),
    .push_data_o(push_data)
  );

  itrt_fifo #(
    .WIDTH(ITEM_W)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .pop_data_o (pop_data)
  );

  itrt_back #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .pop_data_i   (pop_data),
    .pop_o        (pop),
    .digit_valid_o(digit_valid_o),
    .digit_char_o (digit_char_o),
    .last_o       (last_o)
  );

  assign busy_o = full;

endmodule

// ===== hw/rtl/itrt_checker.sv =====
module itrt_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        busy_o,
  input logic                        digit_valid_o,
  input logic [itrt_pkg::CHAR_W-1:0] digit_char_o,
  input logic                        last_o
);

  a_last_has_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> digit_valid_o)
    else $error("last without a digit");

  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    digit_valid_o |-> ((digit_char_o >= 7'd48 && digit_char_o <= 7'd57) ||
                       (digit_char_o >= 7'd97 && digit_char_o <= 7'd122)))
    else $error("digit character out of range");

  a_digits_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (digit_valid_o && !last_o) |=> digit_valid_o)
    else $error("gap inside a word's digits");

  a_no_output_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !digit_valid_o && !busy_o)
    else $error("activity right after reset");

endmodule

bind integer_to_radix_text itrt_checker u_itrt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .busy_o       (busy_o),
  .digit_valid_o(digit_valid_o),
  .digit_char_o (digit_char_o),
  .last_o       (last_o)
);

// ===== verif/integer_to_radix_text_test.sv =====
module integer_to_radix_text_test;

  localparam int unsigned CHAR_W       = itrt_pkg::CHAR_W;
  localparam int unsigned RADIX_W      = itrt_pkg::RADIX_W;
  localparam int unsigned IN_W         = itrt_pkg::IN_W;
  localparam int unsigned LIMIT_CYCLES = 4_000_000;
  localparam int unsigned NUM_PHASES   = 7;
  localparam int unsigned PHASE_WORDS  = 17;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } text_char_t;

  typedef struct {
    bit          is_radix;
    logic [63:0] data;
    string       text;
  } plan_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic [IN_W-1:0]    value_i = '0;
  logic               radix_we_i = 1'b0;
  logic [RADIX_W-1:0] radix_i = '0;
  logic               busy_o;
  logic               digit_valid_o;
  logic [CHAR_W-1:0]  digit_char_o;
  logic               last_o;

  text_char_t         text_chars[$];
  plan_row_t          plan_rows[$];
  logic [RADIX_W-1:0] radix_now = itrt_pkg::RADIX_RESET;
  int unsigned        bad_count = 0;
  bit                 idle_on = 1'b1;

  integer_to_radix_text i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .value_i      (value_i),
    .radix_we_i   (radix_we_i),
    .radix_i      (radix_i),
    .digit_valid_o(digit_valid_o),
    .digit_char_o (digit_char_o),
    .last_o       (last_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic void note_bad(string msg);
    bad_count++;
    if (bad_count <= 10) $display("%s", msg);
  endfunction

  // digits found low first, then queued high first
  function automatic void radix_text(logic [63:0] v);
    logic [RADIX_W-1:0] digs[64];
    logic [63:0]        q;
    logic [63:0]        base;
    int                 n;
    text_char_t         c;
    q    = v;
    base = 64'(radix_now);
    n    = 0;
    if (q == 0) begin
      digs[0] = '0;
      n = 1;
    end
    while (q != 0 && n < 64) begin
      digs[n] = RADIX_W'(q % base);
      q = q / base;
      n++;
    end
    for (int k = n - 1; k >= 0; k--) begin
      c.code = CHAR_W'(digs[k]) + ((digs[k] > itrt_pkg::DIGIT_NINE) ?
                                   itrt_pkg::CHAR_A_OFFS : itrt_pkg::CHAR_ZERO);
      c.last = (k == 0);
      text_chars.push_back(c);
    end
  endfunction

  function automatic void typed_text(string s);
    text_char_t c;
    for (int k = 0; k < s.len(); k++) begin
      c.code = CHAR_W'(s[k]);
      c.last = (k == s.len() - 1);
      text_chars.push_back(c);
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 200);
  endfunction

  function automatic logic [63:0] rand_value();
    int unsigned sel;
    int unsigned len;
    logic [63:0] v;
    sel = $urandom_range(0, 19);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    len = $urandom_range(1, 64);
    v   = {$urandom, $urandom};
    return v & ({64{1'b1}} >> (64 - len));
  endfunction

  function automatic void add_row(bit is_radix, logic [63:0] data, string text);
    plan_row_t row;
    row.is_radix = is_radix;
    row.data     = data;
    row.text     = text;
    plan_rows.push_back(row);
  endfunction

  task automatic wait_idle();
    start_i <= 1'b0;
    while (text_chars.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_radix(logic [RADIX_W-1:0] r);
    wait_idle();
    radix_we_i <= 1'b1;
    radix_i    <= r;
    @(posedge clk_i);
    radix_we_i <= 1'b0;
    radix_i    <= RADIX_W'($urandom);
    radix_now = (r < itrt_pkg::RADIX_MIN) ? itrt_pkg::RADIX_MIN :
                (r > itrt_pkg::RADIX_MAX) ? itrt_pkg::RADIX_MAX : r;
  endtask

  task automatic send_value(logic [63:0] v, string text);
    int unsigned gap;
    start_i <= 1'b1;
    value_i <= v;
    do @(posedge clk_i); while (busy_o);
    if (text.len() > 0) typed_text(text);
    else radix_text(v);
    gap = pick_gap();
    if (gap > 0) begin
      start_i <= 1'b0;
      value_i <= {$urandom, $urandom};
      repeat (gap) @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin
    text_char_t want;
    if (rst_ni && digit_valid_o === 1'b1) begin
      if (text_chars.size() == 0) begin
        note_bad($sformatf("unexpected word: char %0d last %0b", digit_char_o, last_o));
      end else begin
        want = text_chars.pop_front();
        if (digit_char_o !== want.code)
          note_bad($sformatf("digit_char: expected %0d, got %0d", want.code, digit_char_o));
        if (last_o !== want.last)
          note_bad($sformatf("last: expected %0b, got %0b", want.last, last_o));
      end
    end
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("integer_to_radix_text: mismatch");
    $finish;
  end

  initial begin
    logic [RADIX_W-1:0] phase_radix[NUM_PHASES];
    phase_radix = '{6'd2, 6'd36, 6'd0, 6'd63, 6'd1, 6'd37, 6'd10};

    add_row(1'b0, 64'd0, "0");
    add_row(1'b0, 64'd9, "9");
    add_row(1'b0, 64'd10, "10");
    add_row(1'b0, '1, "18446744073709551615");
    add_row(1'b1, 64'd16, "");
    add_row(1'b0, '1, "ffffffffffffffff");
    add_row(1'b0, 64'h8000_0000_0000_0000, "8000000000000000");
    add_row(1'b0, 64'ha, "a");
    add_row(1'b1, 64'd0, "");     // saturates to 2
    add_row(1'b0, '1, "1111111111111111111111111111111111111111111111111111111111111111");
    add_row(1'b0, 64'd1, "1");
    add_row(1'b0, 64'd0, "0");
    add_row(1'b0, 64'h8000_0000_0000_0000, "");
    add_row(1'b1, 64'd1, "");
    add_row(1'b0, 64'd5, "101");
    add_row(1'b1, 64'd63, "");    // saturates to 36
    add_row(1'b0, 64'd35, "z");
    add_row(1'b0, 64'd36, "10");
    add_row(1'b0, '1, "");
    add_row(1'b1, 64'd37, "");
    add_row(1'b0, 64'd1295, "zz");
    add_row(1'b1, 64'd36, "");
    add_row(1'b0, 64'h5555_5555_5555_5555, "");
    add_row(1'b1, 64'd2, "");
    add_row(1'b0, 64'haaaa_aaaa_aaaa_aaaa, "");
    add_row(1'b1, 64'd3, "");
    add_row(1'b0, '1, "");

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan_rows[i]) begin
      if (plan_rows[i].is_radix) set_radix(plan_rows[i].data[RADIX_W-1:0]);
      else send_value(plan_rows[i].data, plan_rows[i].text);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == 0) set_radix(phase_radix[p]);
      else if ($urandom_range(0, 2) == 0) set_radix(RADIX_W'($urandom));
      else set_radix(phase_radix[p]);
      idle_on = (p % 3 != 1);
      for (int n = 0; n < PHASE_WORDS; n++) send_value(rand_value(), "");
    end

    wait_idle();
    repeat (100) @(posedge clk_i);
    bad_count += text_chars.size();
    if (bad_count == 0) begin
      $display("integer_to_radix_text: match");
    end else begin
      $display("integer_to_radix_text: mismatch");
    end
    $finish;
  end

endmodule
